// ===== src/obdpid_pkg.sv =====
`timescale 1ns / 1ps

package obdpid_pkg;

    localparam int WIN_LEN          = 11;
    localparam int MAX_RESPONSE_LEN = 128;
    localparam int CFG_IDX_W        = 3;

    localparam logic [7:0] CHAR_FOUR = 8'h34;
    localparam logic [7:0] CHAR_ONE  = 8'h31;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_REQUESTED_PID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_CODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COOLANT_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_CODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FUEL_TRIM     = 3'd5;

    localparam logic [7:0] RST_RPM_CODE     = 8'd12;
    localparam logic [7:0] RST_SPEED_CODE   = 8'd13;
    localparam logic [7:0] RST_COOLANT_CODE = 8'd5;
    localparam logic [7:0] RST_VOLTAGE_CODE = 8'd66;
    localparam logic [7:0] RST_FUEL_TRIM    = 8'd6;

    localparam logic [15:0] COOLANT_OFFSET   = 16'd40;
    localparam logic [15:0] FUEL_TRIM_OFFSET = 16'd128;

    // x / 1000 == (x * 67109) >> 26 for every 16-bit x.
    localparam logic [16:0] VOLT_RECIP       = 17'd67109;
    localparam int          VOLT_SHIFT       = 26;

    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_RPM,
        KIND_SPEED,
        KIND_COOLANT,
        KIND_VOLTAGE,
        KIND_FUEL_TRIM
    } scale_kind_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
            end
            return d[3:0];
        end
    endfunction

    function automatic logic [7:0] pair_of(input logic [7:0] hi, input logic [7:0] lo);
        return {nibble_of(hi), nibble_of(lo)};
    endfunction

endpackage

// ===== src/obdpid_cell.sv =====
`timescale 1ns / 1ps

module obdpid_cell
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  obdpid_pkg::cell_ctrl_t  ctrl,
    input  logic [7:0]              din,
    input  logic                    din_full,
    output logic [7:0]              dout,
    output logic                    dout_full
);

    logic [7:0] byte_reg;
    logic       full_reg;
    logic       full_next;

    always_comb
    begin
        full_next = full_reg;
        if (ctrl.clear) begin
            full_next = 1'b0;
        end else if (ctrl.shift) begin
            full_next = din_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    // The byte needs no clearing: an empty cell is never looked at.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift) begin
            byte_reg <= din;
        end
    end

    assign dout      = byte_reg;
    assign dout_full = full_reg;

endmodule

// ===== src/obdpid_scale.sv =====
`timescale 1ns / 1ps

module obdpid_scale
(
    input  obdpid_pkg::scale_kind_t kind,
    input  logic [7:0]              a,
    input  logic [7:0]              b,
    output logic [15:0]             value
);

    logic [15:0] ab;
    logic [32:0] volt_prod;

    assign ab        = {a, b};
    assign volt_prod = {17'd0, ab} * {16'd0, obdpid_pkg::VOLT_RECIP};

    always_comb
    begin
        unique case (kind)
            obdpid_pkg::KIND_RPM:       value = {2'b00, ab[15:2]};
            obdpid_pkg::KIND_SPEED:     value = {8'h00, a};
            obdpid_pkg::KIND_COOLANT:   value = {8'h00, a} - obdpid_pkg::COOLANT_OFFSET;
            obdpid_pkg::KIND_VOLTAGE:
                value = {9'd0, volt_prod[32:obdpid_pkg::VOLT_SHIFT]};
            obdpid_pkg::KIND_FUEL_TRIM: value = {8'h00, a} - obdpid_pkg::FUEL_TRIM_OFFSET;
            default:                    value = {8'h00, a};
        endcase
    end

endmodule

// ===== src/obd_pid_response_decoder.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Beat contents
// s_*      in         tdata[7:0] response_byte, tlast last_byte
// m_*      out        tdata[0] found, tdata[16:1] value, tdata[23:17] zero
// cfg_*    in         cfg_index register index, cfg_data value (bits 7:0)
//
// One byte a cycle: the byte shifts into a row of ten cells and the record
// match is made against the row and the incoming byte in the same cycle. A
// result passes the capture stage after its last beat, then the output stage,
// which registers the scaled value (the divide by 1000 is a reciprocal multiply).
// Reset clears the cells, counters and valid flags at once. A stall on m_tready
// holds the two result stages; s_tready drops only when both are full.

module obd_pid_response_decoder
#(
    parameter int MAX_RESPONSE_LEN = obdpid_pkg::MAX_RESPONSE_LEN
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] response_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // [0] found, [16:1] value
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [obdpid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);

    localparam int WIN = obdpid_pkg::WIN_LEN;
    localparam int CW  = $clog2(MAX_RESPONSE_LEN + 1);

    // Configuration registers.
    logic [7:0] req_pid_reg, rpm_code_reg, speed_code_reg;
    logic [7:0] coolant_code_reg, voltage_code_reg, fuel_trim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_pid_reg      <= 8'd0;
            rpm_code_reg     <= obdpid_pkg::RST_RPM_CODE;
            speed_code_reg   <= obdpid_pkg::RST_SPEED_CODE;
            coolant_code_reg <= obdpid_pkg::RST_COOLANT_CODE;
            voltage_code_reg <= obdpid_pkg::RST_VOLTAGE_CODE;
            fuel_trim_reg    <= obdpid_pkg::RST_FUEL_TRIM;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                obdpid_pkg::REG_REQUESTED_PID: req_pid_reg      <= cfg_data;
                obdpid_pkg::REG_RPM_CODE:      rpm_code_reg     <= cfg_data;
                obdpid_pkg::REG_SPEED_CODE:    speed_code_reg   <= cfg_data;
                obdpid_pkg::REG_COOLANT_CODE:  coolant_code_reg <= cfg_data;
                obdpid_pkg::REG_VOLTAGE_CODE:  voltage_code_reg <= cfg_data;
                obdpid_pkg::REG_FUEL_TRIM:     fuel_trim_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake and pipeline control.
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic s1_move, s1_free, in_acc, process;

    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s1_free  = !s1_valid_reg || s1_move;
    assign s_tready = s1_free;
    assign in_acc   = s_tvalid && s1_free;

    logic [CW-1:0] byte_cnt_reg, byte_cnt_next;
    assign process = in_acc && (byte_cnt_reg < CW'(MAX_RESPONSE_LEN));

    // Window cells: cell WIN-1 takes the new byte, each cell hands on to the one below.
    obdpid_pkg::cell_ctrl_t cell_ctrl;
    logic [7:0] cell_byte [1:WIN-1];
    logic       cell_full [1:WIN-1];

    assign cell_ctrl.shift = process;
    assign cell_ctrl.clear = in_acc && s_tlast;

    genvar gi;
    generate
        for (gi = 1; gi < WIN; gi++) begin : g_cell
            if (gi == WIN - 1) begin : g_head
                obdpid_cell u_cell
                (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (cell_ctrl),
                    .din       (s_tdata),
                    .din_full  (1'b1),
                    .dout      (cell_byte[gi]),
                    .dout_full (cell_full[gi])
                );
            end else begin : g_body
                obdpid_cell u_cell
                (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (cell_ctrl),
                    .din       (cell_byte[gi+1]),
                    .din_full  (cell_full[gi+1]),
                    .dout      (cell_byte[gi]),
                    .dout_full (cell_full[gi])
                );
            end
        end
    endgenerate

    // Match against the window as it stands after this byte shifts in:
    // offset j of that window is cell j+1, and offset 10 is the incoming byte.
    logic       matched_reg, matched_next;
    logic [7:0] cap_a_reg, cap_a_next, cap_b_reg, cap_b_next;
    logic       hit;
    logic [7:0] new_a, new_b;

    assign new_a = obdpid_pkg::pair_of(cell_byte[7], cell_byte[8]);
    assign new_b = obdpid_pkg::pair_of(cell_byte[10], s_tdata);
    assign hit   = process && cell_full[1] && !matched_reg
                   && cell_byte[1] == obdpid_pkg::CHAR_FOUR
                   && cell_byte[2] == obdpid_pkg::CHAR_ONE
                   && obdpid_pkg::pair_of(cell_byte[4], cell_byte[5]) == req_pid_reg;

    logic fin_found;
    logic [7:0] fin_a, fin_b;
    assign fin_found = matched_reg || hit;
    assign fin_a     = hit ? new_a : cap_a_reg;
    assign fin_b     = hit ? new_b : cap_b_reg;

    always_comb
    begin
        byte_cnt_next = byte_cnt_reg;
        matched_next  = matched_reg;
        cap_a_next    = cap_a_reg;
        cap_b_next    = cap_b_reg;
        if (in_acc && s_tlast) begin
            byte_cnt_next = '0;
            matched_next  = 1'b0;
            cap_a_next    = 8'd0;
            cap_b_next    = 8'd0;
        end else begin
            if (process) begin
                byte_cnt_next = byte_cnt_reg + CW'(1);
            end
            if (hit) begin
                matched_next = 1'b1;
                cap_a_next   = new_a;
                cap_b_next   = new_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_cnt_reg <= '0;
            matched_reg  <= 1'b0;
            cap_a_reg    <= 8'd0;
            cap_b_reg    <= 8'd0;
        end else begin
            byte_cnt_reg <= byte_cnt_next;
            matched_reg  <= matched_next;
            cap_a_reg    <= cap_a_next;
            cap_b_reg    <= cap_b_next;
        end
    end

    // Scaling kind, first match wins in the order rpm, speed, coolant, voltage, fuel trim.
    obdpid_pkg::scale_kind_t kind_sel;

    always_comb
    begin
        if (!fin_found) begin
            kind_sel = obdpid_pkg::KIND_PLAIN;
        end else if (req_pid_reg == rpm_code_reg) begin
            kind_sel = obdpid_pkg::KIND_RPM;
        end else if (req_pid_reg == speed_code_reg) begin
            kind_sel = obdpid_pkg::KIND_SPEED;
        end else if (req_pid_reg == coolant_code_reg) begin
            kind_sel = obdpid_pkg::KIND_COOLANT;
        end else if (req_pid_reg == voltage_code_reg) begin
            kind_sel = obdpid_pkg::KIND_VOLTAGE;
        end else if (req_pid_reg == fuel_trim_reg) begin
            kind_sel = obdpid_pkg::KIND_FUEL_TRIM;
        end else begin
            kind_sel = obdpid_pkg::KIND_PLAIN;
        end
    end

    // Capture stage.
    logic                    s1_found_reg;
    logic [7:0]              s1_a_reg, s1_b_reg;
    obdpid_pkg::scale_kind_t s1_kind_reg;
    logic                    s1_load;

    assign s1_load = in_acc && s_tlast;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    // A miss loads zeros with the plain kind so the scaled value comes out zero.
    always_ff @(posedge clk)
    begin
        if (s1_load) begin
            s1_found_reg <= fin_found;
            s1_a_reg     <= fin_found ? fin_a : 8'd0;
            s1_b_reg     <= fin_found ? fin_b : 8'd0;
            s1_kind_reg  <= kind_sel;
        end
    end

    // Output stage.
    logic [15:0] scaled;
    logic        m_found_reg;
    logic [15:0] m_value_reg;

    obdpid_scale u_scale
    (
        .kind  (s1_kind_reg),
        .a     (s1_a_reg),
        .b     (s1_b_reg),
        .value (scaled)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (s1_move) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move) begin
            m_found_reg <= s1_found_reg;
            m_value_reg <= scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_value_reg, m_found_reg};

endmodule

// ===== verif/tb_obd_pid_response_decoder.sv =====
`timescale 1ns / 1ps

import obdpid_pkg::*;

typedef struct packed {
    logic [15:0] value;
    logic        found;
} pid_result_t;

// Tracks the decoder's registers and per-response state, and keeps the
// results still owed by the block in arrival order.
class pid_scoreboard;
    logic [7:0]  regs [6];
    logic [7:0]  win [WIN_LEN];
    int unsigned filled;
    int unsigned resp_len;
    bit          hit;
    logic [7:0]  cap_a;
    logic [7:0]  cap_b;
    pid_result_t owed_q [$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned responses;
    int unsigned hits;
    int unsigned results_checked;
    int unsigned reg_writes;

    function new();
        regs[REG_REQUESTED_PID] = 8'h00;
        regs[REG_RPM_CODE]      = RST_RPM_CODE;
        regs[REG_SPEED_CODE]    = RST_SPEED_CODE;
        regs[REG_COOLANT_CODE]  = RST_COOLANT_CODE;
        regs[REG_VOLTAGE_CODE]  = RST_VOLTAGE_CODE;
        regs[REG_FUEL_TRIM]     = RST_FUEL_TRIM;
        clear_response();
    endfunction

    function void clear_response();
        foreach (win[i])
            win[i] = 8'h00;
        filled   = 0;
        resp_len = 0;
        hit      = 1'b0;
        cap_a    = 8'h00;
        cap_b    = 8'h00;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        reg_writes++;
        if (idx <= REG_FUEL_TRIM)
            regs[idx] = data;
    endfunction

    // ASCII hex digit to its value; anything else counts as zero.
    function logic [3:0] hex_digit(logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39)
            return ch[3:0];
        if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
            return ch[3:0] + 4'd9;
        return 4'd0;
    endfunction

    function logic [7:0] hex_byte(logic [7:0] hi, logic [7:0] lo);
        return {hex_digit(hi), hex_digit(lo)};
    endfunction

    // The first code that equals the requested PID picks the scaling.
    function scale_kind_t kind_of();
        logic [7:0] pid;
        pid = regs[REG_REQUESTED_PID];
        if (pid == regs[REG_RPM_CODE])
            return KIND_RPM;
        if (pid == regs[REG_SPEED_CODE])
            return KIND_SPEED;
        if (pid == regs[REG_COOLANT_CODE])
            return KIND_COOLANT;
        if (pid == regs[REG_VOLTAGE_CODE])
            return KIND_VOLTAGE;
        if (pid == regs[REG_FUEL_TRIM])
            return KIND_FUEL_TRIM;
        return KIND_PLAIN;
    endfunction

    function logic [15:0] scaled();
        logic [15:0] ab;
        logic [15:0] a16;
        ab  = {cap_a, cap_b};
        a16 = {8'h00, cap_a};
        case (kind_of())
            KIND_RPM:       return ab >> 2;
            KIND_COOLANT:   return a16 - COOLANT_OFFSET;
            KIND_VOLTAGE:   return ab / 16'd1000;
            KIND_FUEL_TRIM: return a16 - FUEL_TRIM_OFFSET;
            default:        return a16;
        endcase
    endfunction

    function void note_byte(logic [7:0] ch, logic last);
        pid_result_t r;
        bytes_seen++;
        // Bytes beyond the length limit are dropped, but the last beat still closes.
        if (resp_len < MAX_RESPONSE_LEN) begin
            for (int i = 0; i < WIN_LEN - 1; i++)
                win[i] = win[i + 1];
            win[WIN_LEN - 1] = ch;
            resp_len++;
            if (filled < WIN_LEN)
                filled++;
            if (filled == WIN_LEN && !hit && win[0] == CHAR_FOUR && win[1] == CHAR_ONE &&
                hex_byte(win[3], win[4]) == regs[REG_REQUESTED_PID]) begin
                hit   = 1'b1;
                cap_a = hex_byte(win[6], win[7]);
                cap_b = hex_byte(win[9], win[10]);
            end
        end
        if (last) begin
            r.found = hit;
            r.value = hit ? scaled() : 16'h0000;
            owed_q.push_back(r);
            responses++;
            if (hit)
                hits++;
            clear_response();
        end
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    task report(string what);
        errors++;
        $display("MISMATCH at result %0d: %s", results_checked, what);
    endtask

    task check_result(logic [23:0] beat);
        pid_result_t want;
        results_checked++;
        if (owed_q.size() == 0) begin
            report($sformatf("beat %h arrived with no response outstanding", beat));
            return;
        end
        want = owed_q.pop_front();
        if (beat[0] !== want.found)
            report($sformatf("found %b, expected %b", beat[0], want.found));
        if (beat[16:1] !== want.value)
            report($sformatf("value %0d, expected %0d", beat[16:1], want.value));
        if (beat[23:17] !== 7'h00)
            report($sformatf("pad bits %h, expected zero", beat[23:17]));
    endtask
endclass

module tb_obd_pid_response_decoder;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 6;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;   // [7:0] response_byte
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;             // [0] found, [16:1] value, [23:17] zero
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_REQUESTED_PID;
    logic [7:0]           cfg_data  = 8'h00;

    pid_scoreboard sb = new();

    logic [7:0]  resp [$];
    logic [7:0]  cur_req      = 8'h00;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          rx_hold_left = 0;
    int          stall_cycles = 0;
    int          settings     = 0;

    obd_pid_response_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random back-pressure, or a solid hold-off while rx_hold_left runs down.
    always @(posedge clk)
    begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Results are checked before the same edge's input beat is noted, so a
    // result can never be matched against the response that just closed.
    always @(posedge clk)
    begin : monitor
        bit moved;
        if (rst_n) begin
            moved = 1'b0;
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                moved = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata, s_tlast);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                sb.set_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        return (lower ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
    endfunction

    // Separator followed by two hex digits; the separator is sometimes garbage.
    function automatic void push_field(input logic [7:0] v, input bit lower);
        resp.push_back(($urandom_range(7) == 0) ? 8'($urandom) : 8'h20);
        resp.push_back(hex_char(v[7:4], lower));
        resp.push_back(hex_char(v[3:0], lower));
    endfunction

    function automatic void push_record(input logic [7:0] pid, input logic [7:0] a,
                                        input logic [7:0] b);
        bit lower;
        lower = ($urandom_range(1) == 1);
        resp.push_back(CHAR_FOUR);
        resp.push_back(CHAR_ONE);
        push_field(pid, lower);
        push_field(a, lower);
        push_field(b, lower);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            resp.push_back(s[i]);
    endfunction

    function automatic void make_random_response();
        int form;
        form = $urandom_range(99);
        resp.delete();
        if (form < 55) begin
            // Echo or prompt text, one to three records, then line endings.
            repeat ($urandom_range(0, 5))
                resp.push_back(8'($urandom_range(32, 126)));
            repeat ($urandom_range(1, 3))
                push_record(($urandom_range(99) < 70) ? cur_req : 8'($urandom),
                            8'($urandom), 8'($urandom));
            repeat ($urandom_range(0, 2))
                resp.push_back(($urandom_range(1) == 1) ? 8'h0D : 8'h3E);
        end else if (form < 70) begin
            // Record cut short by the end of the response.
            repeat ($urandom_range(0, 3))
                resp.push_back(8'($urandom_range(32, 126)));
            push_record(cur_req, 8'($urandom), 8'($urandom));
            repeat ($urandom_range(1, 10))
                void'(resp.pop_back());
        end else if (form < 82) begin
            push_record(cur_req, 8'($urandom), 8'($urandom));
            repeat ($urandom_range(1, 3))
                resp[$urandom_range(0, 10)] = 8'($urandom);
        end else if (form < 97) begin
            repeat ($urandom_range(1, 16))
                resp.push_back(8'($urandom));
        end else begin
            // Long response whose record lands around the length limit.
            repeat ($urandom_range(110, 125))
                resp.push_back(8'($urandom_range(32, 126)));
            push_record(cur_req, 8'($urandom), 8'($urandom));
            repeat ($urandom_range(0, 4))
                resp.push_back(8'h3E);
        end
    endfunction

    // Valid stays high from one beat to the next unless the sender idles.
    task automatic send_byte(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_response();
        foreach (resp[i])
            send_byte(resp[i], i == resp.size() - 1);
        resp.delete();
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_response();
    endtask

    // Wait until every owed result is out, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_regs(input logic [7:0] req, input logic [7:0] rpm,
                             input logic [7:0] spd, input logic [7:0] cool,
                             input logic [7:0] volt, input logic [7:0] fuel);
        put_reg(REG_REQUESTED_PID, req);
        put_reg(REG_RPM_CODE, rpm);
        put_reg(REG_SPEED_CODE, spd);
        put_reg(REG_COOLANT_CODE, cool);
        put_reg(REG_VOLTAGE_CODE, volt);
        put_reg(REG_FUEL_TRIM, fuel);
        cfg_valid <= 1'b0;
        cur_req = req;
        settings++;
    endtask

    initial
    begin : stimulus
        int         phase_bytes;
        logic [7:0] req;
        logic [7:0] rc [5];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset register values first.
        send_text("41 00 7F 80");
        send_text("?");
        drain();
        load_regs(RST_RPM_CODE, RST_RPM_CODE, RST_SPEED_CODE, RST_COOLANT_CODE,
                  RST_VOLTAGE_CODE, RST_FUEL_TRIM);
        send_text("41 0C FF FF");
        send_text("010C\01541 0c 00 00\015\015>");
        send_text("41 0D 11 22 41 0C 12 34 41 0C 56 78");
        send_text("41x0C-1azF8");
        send_text("41 0C 1A");
        drain();
        load_regs(RST_COOLANT_CODE, RST_RPM_CODE, RST_SPEED_CODE, RST_COOLANT_CODE,
                  RST_VOLTAGE_CODE, RST_FUEL_TRIM);
        send_text("41 05 00 00");
        send_text("41 05 FF 00");
        drain();
        load_regs(RST_VOLTAGE_CODE, RST_RPM_CODE, RST_SPEED_CODE, RST_COOLANT_CODE,
                  RST_VOLTAGE_CODE, RST_FUEL_TRIM);
        send_text("41 42 FF FF");
        send_text("41 42 30 39");
        drain();
        load_regs(RST_FUEL_TRIM, RST_RPM_CODE, RST_SPEED_CODE, RST_COOLANT_CODE,
                  RST_VOLTAGE_CODE, RST_FUEL_TRIM);
        send_text("41 06 00 00");
        send_text("41 06 FF 80");
        drain();
        load_regs(RST_SPEED_CODE, RST_RPM_CODE, RST_SPEED_CODE, RST_COOLANT_CODE,
                  RST_VOLTAGE_CODE, RST_FUEL_TRIM);
        send_text("41 0D FF 00");
        // Every code equal to the request: engine speed scaling has priority.
        drain();
        load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_text("41 00 80 01");
        // Non-hex PID digits read as zero and match a request of zero.
        drain();
        load_regs(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_text("41 G! AB CD");
        // A record starting past the length limit is ignored; one ending on it counts.
        repeat (MAX_RESPONSE_LEN + 2)
            resp.push_back(8'h5A);
        push_text("41 00 11 22");
        send_response();
        repeat (MAX_RESPONSE_LEN - WIN_LEN)
            resp.push_back(8'h5A);
        push_text("41 00 33 44");
        send_response();

        // Random part, nine register settings under three idling schemes.
        for (int ph = 0; ph < 9; ph++) begin
            drain();
            case (ph / 3)
                0: begin src_idle_pct = 21; snk_idle_pct = 72; end
                1: begin src_idle_pct = 72; snk_idle_pct = 21; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            if (ph < 5) begin
                case (ph)
                    0: req = RST_RPM_CODE;
                    1: req = RST_SPEED_CODE;
                    2: req = RST_COOLANT_CODE;
                    3: req = RST_VOLTAGE_CODE;
                    default: req = RST_FUEL_TRIM;
                endcase
                load_regs(req, RST_RPM_CODE, RST_SPEED_CODE, RST_COOLANT_CODE,
                          RST_VOLTAGE_CODE, RST_FUEL_TRIM);
            end else if (ph == 5) begin
                load_regs(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF);
            end else begin
                foreach (rc[i])
                    rc[i] = 8'($urandom);
                req = ($urandom_range(3) == 0) ? 8'($urandom) : rc[$urandom_range(0, 4)];
                load_regs(req, rc[0], rc[1], rc[2], rc[3], rc[4]);
            end
            if (ph == 1) begin
                // Hold the result side off so both result stages fill and input stalls.
                rx_hold_left = 300;
                repeat (6) begin
                    push_record(cur_req, 8'($urandom), 8'($urandom));
                    send_response();
                end
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                make_random_response();
                phase_bytes += resp.size();
                send_response();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d bytes in %0d responses, %0d of them with a matching record,",
                 sb.bytes_seen, sb.responses, sb.hits);
        $display("under %0d register settings (%0d register writes) and three idling schemes.",
                 settings, sb.reg_writes);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
